// ===== rtl/core/priority_key_debounce_long_press_macros.svh =====
// Assertion macros used by the checker file of the key debounce block.
`ifndef PRIORITY_KEY_DEBOUNCE_LONG_PRESS_MACROS_SVH
`define PRIORITY_KEY_DEBOUNCE_LONG_PRESS_MACROS_SVH

// Clocked assertion that is switched off while the reset is asserted.
`define PKDLP_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define PKDLP_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/pkdlp_pkg.sv =====
// Shared types and constants of the priority key debounce block.
package pkdlp_pkg;

  localparam int unsigned PinCount      = 6;
  localparam int unsigned KeyCount      = 6;
  localparam int unsigned CounterWidth  = 16;
  localparam int unsigned KeyScan       = (KeyCount < PinCount) ? KeyCount : PinCount;
  localparam int unsigned DebounceW     = 8;
  localparam int unsigned LongPressW    = 16;
  localparam int unsigned CfgIndexW     = 1;
  localparam int unsigned CfgDataW      = 16;
  localparam int unsigned InTdataW      = 8;
  localparam int unsigned OutTdataW     = 8;

  localparam logic [DebounceW-1:0]  DebounceReset  = 8'd5;
  localparam logic [LongPressW-1:0] LongPressReset = 16'd1000;

  typedef logic [2:0]          key_code_t;
  typedef logic [PinCount-1:0] key_levels_t;

  localparam key_code_t KeyUp     = 3'd0;
  localparam key_code_t KeyDown   = 3'd1;
  localparam key_code_t KeyLeft   = 3'd2;
  localparam key_code_t KeyRight  = 3'd3;
  localparam key_code_t KeyLeftX  = 3'd4;
  localparam key_code_t KeyRightX = 3'd5;
  localparam key_code_t KeyLongX  = 3'd6;

  localparam logic [CfgIndexW-1:0] CfgDebounce  = 1'd0;
  localparam logic [CfgIndexW-1:0] CfgLongPress = 1'd1;

  // One sampled tick waiting in the input register.
  typedef struct packed {
    logic        valid;
    key_levels_t levels;
  } pkdlp_item_t;

  // Outcome of one tick: whether a key code is reported, and which.
  typedef struct packed {
    logic      valid;
    key_code_t code;
  } pkdlp_result_t;

endpackage

// ===== rtl/core/pkdlp_in_reg.sv =====
// Input register that holds one key sample until the core consumes it.
module pkdlp_in_reg
  import pkdlp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  key_levels_t in_levels_i,
  input  logic        take_i,
  output pkdlp_item_t item_o
);

  logic        valid_q, valid_d;
  key_levels_t levels_q;
  logic        accept;

  assign in_ready_o = !valid_q || take_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      levels_q <= in_levels_i;
    end
  end

  assign item_o = '{valid: valid_q, levels: levels_q};

endmodule

// ===== rtl/core/pkdlp_core.sv =====
// Debounce state machine, elapsed counter and configuration registers.
module pkdlp_core
  import pkdlp_pkg::*;
#(
  parameter int unsigned CounterW = CounterWidth
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  input  pkdlp_item_t          item_i,
  input  logic                 fire_i,
  output pkdlp_result_t        result_o
);

  localparam int unsigned CmpW = (CounterW > LongPressW) ? CounterW : LongPressW;

  typedef enum logic [1:0] {
    PhIdle     = 2'd0,
    PhDebounce = 2'd1,
    PhHold     = 2'd2
  } phase_e;

  phase_e               phase_q, phase_d;
  key_code_t            held_q, held_d;
  logic [CounterW-1:0]  elapsed_q, elapsed_d, elapsed_inc;
  logic [DebounceW-1:0] debounce_q;
  logic [LongPressW-1:0] long_press_q;
  logic                 held_pressed;
  logic                 found;
  key_code_t            found_key;

  // Saturating tick counter.
  assign elapsed_inc = (&elapsed_q) ? elapsed_q : elapsed_q + 1'b1;
  assign held_pressed = !item_i.levels[held_q];

  // Lowest pin index wins; scanned from the top so the last hit is the winner.
  always_comb begin
    found     = 1'b0;
    found_key = KeyUp;
    for (int k = KeyScan - 1; k >= 0; k--) begin
      if (!item_i.levels[k]) begin
        found     = 1'b1;
        found_key = key_code_t'(k);
      end
    end
  end

  always_comb begin
    phase_d   = phase_q;
    held_d    = held_q;
    elapsed_d = elapsed_q;
    result_o  = '{valid: 1'b0, code: held_q};
    unique case (phase_q)
      PhDebounce: begin
        elapsed_d = elapsed_inc;
        if (CmpW'(elapsed_inc) >= CmpW'(debounce_q)) begin
          phase_d = held_pressed ? PhHold : PhIdle;
        end
      end
      PhHold: begin
        elapsed_d = elapsed_inc;
        if (!held_pressed) begin
          phase_d         = PhIdle;
          result_o.valid  = 1'b1;
          if (held_q == KeyRightX && CmpW'(elapsed_inc) > CmpW'(long_press_q)) begin
            result_o.code = KeyLongX;
          end
        end
      end
      default: begin
        phase_d = PhIdle;
        if (found) begin
          held_d    = found_key;
          elapsed_d = '0;
          phase_d   = PhDebounce;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhIdle;
      held_q    <= KeyUp;
      elapsed_q <= '0;
    end else if (fire_i) begin
      phase_q   <= phase_d;
      held_q    <= held_d;
      elapsed_q <= elapsed_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q   <= DebounceReset;
      long_press_q <= LongPressReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgDebounce:  debounce_q   <= cfg_data_i[DebounceW-1:0];
        CfgLongPress: long_press_q <= cfg_data_i[LongPressW-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/pkdlp_out_reg.sv =====
// Result register that presents a key code until the receiver takes it.
module pkdlp_out_reg
  import pkdlp_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          fire_i,
  input  pkdlp_result_t result_i,
  output logic          load_ok_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output key_code_t     out_code_o
);

  logic      valid_q, valid_d;
  key_code_t code_q;

  assign load_ok_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_ok_o) begin
      valid_d = fire_i && result_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i && result_i.valid) begin
      code_q <= result_i.code;
    end
  end

  assign out_valid_o = valid_q;
  assign out_code_o  = code_q;

endmodule

// ===== rtl/core/priority_key_debounce_long_press.sv =====
// Top level of the priority key debounce and long-press detector.
//
// Usage: each request on the s_axis channel is one tick carrying the six
// active-low key pins. The first pressed key in priority order is latched,
// confirmed after debounce_ticks ticks, and reported on the m_axis channel
// once it is released; a right_x release later than long_press_ticks after
// first detection reports the long code. Most ticks report nothing.
// Configuration writes arrive on the cfg channel (index 0 debounce_ticks,
// index 1 long_press_ticks); cfg_ready_o is always high.
// Path: a tick request is held in the input register and evaluated once the
// result register is free or being taken; a key code it causes is loaded into
// the result register as the evaluation ends, raising m_axis_tvalid.
// Throughput: one tick per cycle while the receiver is not stalling, set by the
// state update that sits between the input register and the result register.
// Reset: the machine is idle, no key is held, the counter is zero and the
// registers return to 5 and 1000. When the receiver stalls, the result
// register holds its code and one more tick waits in the input register;
// after that s_axis_tready drops until the result is taken.
module priority_key_debounce_long_press
  import pkdlp_pkg::*;
#(
  parameter int unsigned CounterW = CounterWidth
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [InTdataW-1:0]  s_axis_tdata,   // [5:0] key_levels
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OutTdataW-1:0] m_axis_tdata,   // [2:0] key_code
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i
);

  pkdlp_item_t   item;
  pkdlp_result_t result;
  logic          load_ok;
  logic          fire;
  key_code_t     out_code;

  assign cfg_ready_o = 1'b1;
  assign fire        = item.valid && load_ok;

  pkdlp_in_reg u_in_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_levels_i (s_axis_tdata[PinCount-1:0]),
    .take_i      (fire),
    .item_o      (item)
  );

  pkdlp_core #(
    .CounterW (CounterW)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .item_i      (item),
    .fire_i      (fire),
    .result_o    (result)
  );

  pkdlp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .result_i    (result),
    .load_ok_o   (load_ok),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_code_o  (out_code)
  );

  assign m_axis_tdata = {{(OutTdataW - 3){1'b0}}, out_code};

endmodule

// ===== rtl/core/pkdlp_checker.sv =====
// Port-level checker for the key debounce block and its bind statement.
`include "priority_key_debounce_long_press_macros.svh"

module pkdlp_checker
  import pkdlp_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [OutTdataW-1:0] m_axis_tdata,
  input logic                 cfg_ready_o
);

  `PKDLP_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "Stalled result changed or vanished.")

  `PKDLP_ASSERT(a_code_range, clk_i, rst_ni, m_axis_tvalid |-> (m_axis_tdata <= OutTdataW'(KeyLongX)), "Result code out of range.")

  // A result after an empty cycle comes from a request taken on s_axis, through the input and result registers.
  `PKDLP_ASSERT(a_result_source, clk_i, rst_ni, (m_axis_tvalid && !$past(m_axis_tvalid)) |-> $past(s_axis_tvalid && s_axis_tready, 2), "Result without a recent request.")

  `PKDLP_ASSERT_ALWAYS(a_cfg_ready, clk_i, cfg_ready_o, "Configuration port refused a write.")

endmodule

bind priority_key_debounce_long_press pkdlp_checker u_pkdlp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .cfg_ready_o   (cfg_ready_o)
);

// ===== bench/tb_priority_key_debounce_long_press.sv =====
// Self-checking testbench for the priority key debounce and long-press block.
`timescale 1ns / 1ps

module tb_priority_key_debounce_long_press;
  import pkdlp_pkg::*;

  typedef enum logic [1:0] {
    ScanIdle     = 2'd0,
    ScanDebounce = 2'd1,
    ScanHold     = 2'd2
  } scan_phase_e;

  typedef struct packed {
    key_levels_t levels;
    logic        typed;
    key_code_t   code;
  } tick_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIndexW-1:0] cfg_index_i = '0;
  logic [CfgDataW-1:0]  cfg_data_i = '0;

  priority_key_debounce_long_press dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the registers and the scan state.
  logic [DebounceW-1:0]    debounce_reg = DebounceReset;
  logic [LongPressW-1:0]   long_press_reg = LongPressReset;
  scan_phase_e             scan_phase = ScanIdle;
  key_code_t               held_key = KeyUp;
  logic [CounterWidth-1:0] elapsed = '0;

  key_code_t pending_codes[$];
  int        mismatches = 0;
  int        codes_seen = 0;
  int        ticks_sent = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        holdoff_left = 0;

  // Directed ticks, run with debounce 0 and long press 2.
  tick_row_t dir_rows [27] = '{
    '{6'h3E, 1'b0, KeyUp},     '{6'h3E, 1'b0, KeyUp},     '{6'h3F, 1'b1, KeyUp},
    // All keys down at once: up wins, the rest stay ignored.
    '{6'h00, 1'b0, KeyUp},     '{6'h00, 1'b0, KeyUp},     '{6'h01, 1'b1, KeyUp},
    '{6'h3D, 1'b0, KeyDown},   '{6'h3D, 1'b0, KeyDown},   '{6'h3F, 1'b1, KeyDown},
    // Left bounces off before the confirming sample, so nothing is reported.
    '{6'h3B, 1'b0, KeyLeft},   '{6'h3F, 1'b0, KeyLeft},
    '{6'h3B, 1'b0, KeyLeft},   '{6'h3B, 1'b0, KeyLeft},   '{6'h3F, 1'b1, KeyLeft},
    '{6'h37, 1'b0, KeyRight},  '{6'h37, 1'b0, KeyRight},  '{6'h3F, 1'b1, KeyRight},
    '{6'h2F, 1'b0, KeyLeftX},  '{6'h2F, 1'b0, KeyLeftX},  '{6'h3F, 1'b1, KeyLeftX},
    '{6'h1F, 1'b0, KeyRightX}, '{6'h1F, 1'b0, KeyRightX}, '{6'h3F, 1'b1, KeyRightX},
    '{6'h1F, 1'b0, KeyRightX}, '{6'h1F, 1'b0, KeyRightX}, '{6'h1F, 1'b0, KeyRightX},
    '{6'h3F, 1'b1, KeyLongX}
  };

  function void scan_tick(input key_levels_t lv, output logic fired, output key_code_t code);
    logic found;
    fired = 1'b0;
    code  = KeyUp;
    found = 1'b0;
    case (scan_phase)
      ScanDebounce: begin
        if (elapsed != '1) elapsed = elapsed + 1'b1;
        if (elapsed >= CounterWidth'(debounce_reg)) begin
          scan_phase = lv[held_key] ? ScanIdle : ScanHold;
        end
      end
      ScanHold: begin
        if (elapsed != '1) elapsed = elapsed + 1'b1;
        if (lv[held_key]) begin
          scan_phase = ScanIdle;
          fired = 1'b1;
          if (held_key == KeyRightX && elapsed > CounterWidth'(long_press_reg)) begin
            code = KeyLongX;
          end else begin
            code = held_key;
          end
        end
      end
      default: begin
        scan_phase = ScanIdle;
        for (int k = 0; k < KeyScan; k++) begin
          if (!found && !lv[k]) begin
            found      = 1'b1;
            held_key   = key_code_t'(k);
            elapsed    = '0;
            scan_phase = ScanDebounce;
          end
        end
      end
    endcase
  endfunction

  task automatic send_tick(input key_levels_t lv, input logic typed, input key_code_t code);
    logic      fired;
    key_code_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(InTdataW - PinCount){1'b0}}, lv};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    ticks_sent++;
    scan_tick(lv, fired, predicted);
    if (typed) pending_codes.push_back(code);
    else if (fired) pending_codes.push_back(predicted);
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (pending_codes.size() != 0) @(posedge clk_i);
    // Ticks that report nothing may still sit in the pipeline.
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == CfgDebounce) debounce_reg = data[DebounceW-1:0];
    else long_press_reg = data;
  endtask

  task automatic set_config(input int deb, input int lp);
    drain();
    // The upper byte of a debounce write is junk that the block must drop.
    write_reg(CfgDebounce, {8'($urandom), 8'(deb)});
    write_reg(CfgLongPress, 16'(lp));
    cfg_valid_i <= 1'b0;
  endtask

  function int debounce_eff();
    return (debounce_reg == 0) ? 1 : int'(debounce_reg);
  endfunction

  // One press of key k: bounce during debounce, then either a drop at the
  // confirming sample or a hold of random length and a release.
  task automatic key_press(input int k);
    key_levels_t lv;
    logic        glitch;
    int          hold;
    glitch = ($urandom_range(99) < 15);
    lv = key_levels_t'($urandom);
    for (int j = 0; j < k; j++) lv[j] = 1'b1;
    lv[k] = 1'b0;
    send_tick(lv, 1'b0, KeyUp);
    repeat (debounce_eff() - 1) send_tick(key_levels_t'($urandom), 1'b0, KeyUp);
    lv = key_levels_t'($urandom);
    lv[k] = glitch;
    send_tick(lv, 1'b0, KeyUp);
    if (!glitch) begin
      hold = $urandom_range((long_press_reg < 60) ? int'(long_press_reg) + 4 : 12, 0);
      repeat (hold) begin
        lv = key_levels_t'($urandom);
        lv[k] = 1'b0;
        send_tick(lv, 1'b0, KeyUp);
      end
      lv = key_levels_t'($urandom);
      lv[k] = 1'b1;
      send_tick(lv, 1'b0, KeyUp);
    end
  endtask

  task automatic run_random(input int n);
    int start;
    start = ticks_sent;
    while (ticks_sent - start < n) begin
      if ($urandom_range(99) < 80) begin
        key_press($urandom_range(KeyScan - 1));
      end else begin
        repeat ($urandom_range(3, 1)) send_tick(key_levels_t'($urandom), 1'b0, KeyUp);
      end
    end
    // All keys up long enough to bring the scan back to idle.
    repeat (debounce_eff() + 2) send_tick('1, 1'b0, KeyUp);
  endtask

  task automatic set_mode(input int send_pct, input int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  always @(posedge clk_i) begin
    if (holdoff_left > 0) begin
      m_axis_tready <= 1'b0;
      holdoff_left--;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    key_code_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      codes_seen++;
      if (pending_codes.size() == 0) begin
        if (mismatches < 10) begin
          $display("%0t: key code %0d reported with none expected", $realtime,
                   m_axis_tdata[2:0]);
        end
        mismatches++;
      end else begin
        want = pending_codes.pop_front();
        if (m_axis_tdata[2:0] !== want) begin
          if (mismatches < 10) begin
            $display("%0t: key_code expected %0d, got %0d", $realtime, want,
                     m_axis_tdata[2:0]);
          end
          mismatches++;
        end
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Register values straight out of reset.
    set_mode(0, 0);
    run_random(80);

    set_config(0, 2);
    foreach (dir_rows[i]) send_tick(dir_rows[i].levels, dir_rows[i].typed, dir_rows[i].code);

    set_config(1, 0);
    set_mode(58, 0);
    run_random(120);

    set_config(3, 17);
    set_mode(0, 58);
    run_random(120);

    set_config($urandom_range(8, 1), $urandom_range(40));
    set_mode(35, 35);
    run_random(120);

    // Long receiver hold-off while ticks keep coming, so the input backs up.
    set_config(2, 10);
    set_mode(0, 0);
    holdoff_left = 300;
    run_random(120);

    set_config(0, 40);
    set_mode(35, 35);
    run_random(80);

    s_axis_tvalid <= 1'b0;
    while (pending_codes.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Sent %0d key ticks, checked %0d key codes over seven register settings,",
             ticks_sent, codes_seen);
    $display("with zero debounce, zero long press, idle and stall phases and a long hold-off.");
    if (mismatches == 0 && pending_codes.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timed out with %0d key codes still expected", pending_codes.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/pkdlp_pkg.sv
rtl/core/pkdlp_in_reg.sv
rtl/core/pkdlp_core.sv
rtl/core/pkdlp_out_reg.sv
rtl/core/priority_key_debounce_long_press.sv
rtl/core/pkdlp_checker.sv
bench/tb_priority_key_debounce_long_press.sv
